// ----- hdl/bhl_pkg.sv -----
// ----------------------------------------------------------------------------
// bhl_pkg: shared definitions for the bounded history log
// Depth, index widths, command and status codes, and the stored record layout.
// ----------------------------------------------------------------------------
package bhl_pkg;

  // Log geometry
  localparam int unsigned LOG_DEPTH = 32;
  localparam int unsigned SLOT_W    = $clog2(LOG_DEPTH);
  localparam int unsigned CNT_W     = $clog2(LOG_DEPTH + 1);

  // Field widths of the request and response
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned KIND_W   = 8;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned FILL_W   = 6;

  // Command codes
  localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_NEXT   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_PREV   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_SHOWN    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NEWEST   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OLDEST   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

  // One stored record
  typedef struct packed {
    logic        [WORD_W-1:0] number;
    logic        [KIND_W-1:0] kind;
    logic signed [WORD_W-1:0] value;
    logic        [WORD_W-1:0] stamp;
  } record_t;

endpackage

// ----- hdl/bounded_history_log_with_cursor.sv -----
// ----------------------------------------------------------------------------
// bounded_history_log_with_cursor: ring log of sensor records with a cursor
// Stores the latest records in one synchronous memory and browses them.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (in_valid_i / in_stall_i style: in_stall_o driven
//   here) carries one command: append, next, previous, clear or show.
//   The response channel (out_valid_o / out_stall_i) returns one response
//   per request: a status, the record under the cursor when status is
//   "shown" (zero fields otherwise), and the fill level after the command.
//   A request is taken while in_stall_o is low; pointers update at once and
//   the record memory is read at the new cursor. The registered read data is
//   moved to the response register once that register is free, and no new
//   request is taken until that move is done. A new request is taken while
//   a finished response still waits. If the receiver stalls, the response
//   holds and the next request waits in the fetch state until the response
//   register frees up.
//   Reset empties the log and restarts numbering at one; the record memory
//   itself is not cleared, only held records are ever shown.
module bounded_history_log_with_cursor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bhl_pkg::ACTION_W-1:0]  action_i,
  input  logic [bhl_pkg::KIND_W-1:0]    sensor_kind_i,
  input  logic signed [bhl_pkg::WORD_W-1:0] sample_value_i,
  input  logic [bhl_pkg::WORD_W-1:0]    stamp_seconds_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bhl_pkg::STATUS_W-1:0]  status_o,
  output logic [bhl_pkg::WORD_W-1:0]    record_number_o,
  output logic [bhl_pkg::KIND_W-1:0]    record_kind_o,
  output logic signed [bhl_pkg::WORD_W-1:0] record_value_o,
  output logic [bhl_pkg::WORD_W-1:0]    record_stamp_o,
  output logic [bhl_pkg::FILL_W-1:0]    fill_level_o
);
  import bhl_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_FETCH
  } state_e;

  // Slot arithmetic modulo the depth
  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_W'(LOG_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    slot_dec = (s == '0) ? SLOT_W'(LOG_DEPTH - 1) : s - SLOT_W'(1);
  endfunction

  state_e                 state_q;
  logic                   out_valid_q;

  logic [SLOT_W-1:0]      oldest_q, oldest_d;
  logic [SLOT_W-1:0]      cursor_q, cursor_d;
  logic [CNT_W-1:0]       held_q, held_d;
  logic [WORD_W-1:0]      next_num_q, next_num_d;

  logic [STATUS_W-1:0]    pend_status_q, pend_status_d;
  logic [FILL_W-1:0]      pend_fill_q, pend_fill_d;

  logic [STATUS_W-1:0]    out_status_q;
  record_t                out_rec_q;
  logic [FILL_W-1:0]      out_fill_q;

  record_t                mem [LOG_DEPTH];
  record_t                rd_q;
  logic                   wr_en;
  logic [SLOT_W-1:0]      wr_slot;
  record_t                wr_rec;

  logic                   in_fire;
  logic                   out_free;

  logic                   full;
  logic [SLOT_W-1:0]      oldest_ev;
  logic [SLOT_W-1:0]      cursor_ev;
  logic [CNT_W-1:0]       held_ev;
  logic [CNT_W:0]         slot_sum;
  logic [CNT_W-1:0]       offset;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Evict the oldest record when full and find the slot for an append
  always_comb begin
    full      = (held_q == CNT_W'(LOG_DEPTH));
    oldest_ev = full ? slot_inc(oldest_q) : oldest_q;
    cursor_ev = (full && (cursor_q == oldest_q)) ? slot_inc(oldest_q) : cursor_q;
    held_ev   = full ? CNT_W'(LOG_DEPTH - 1) : held_q;
    slot_sum  = {{(CNT_W + 1 - SLOT_W){1'b0}}, oldest_ev} + {1'b0, held_ev};
    if (slot_sum >= (CNT_W + 1)'(LOG_DEPTH)) begin
      slot_sum = slot_sum - (CNT_W + 1)'(LOG_DEPTH);
    end
    wr_slot = slot_sum[SLOT_W-1:0];
  end

  // Distance of the cursor from the oldest record
  always_comb begin
    if (cursor_q >= oldest_q) begin
      offset = CNT_W'(cursor_q - oldest_q);
    end else begin
      offset = CNT_W'(cursor_q) + CNT_W'(LOG_DEPTH) - CNT_W'(oldest_q);
    end
  end

  // Decode the request and work out the new pointers
  always_comb begin
    oldest_d      = oldest_q;
    cursor_d      = cursor_q;
    held_d        = held_q;
    next_num_d    = next_num_q;
    pend_status_d = ST_EMPTY;
    wr_en         = 1'b0;
    wr_rec.number = next_num_q;
    wr_rec.kind   = sensor_kind_i;
    wr_rec.value  = sample_value_i;
    wr_rec.stamp  = stamp_seconds_i;
    unique case (action_i)
      ACT_APPEND: begin
        wr_en         = in_fire;
        oldest_d      = oldest_ev;
        held_d        = held_ev + CNT_W'(1);
        cursor_d      = (held_ev == '0) ? wr_slot : cursor_ev;
        next_num_d    = next_num_q + WORD_W'(1);
        pend_status_d = ST_APPENDED;
      end
      ACT_NEXT: begin
        if ((held_q != '0) && ((offset + CNT_W'(1)) < held_q)) begin
          cursor_d      = slot_inc(cursor_q);
          pend_status_d = ST_SHOWN;
        end else begin
          pend_status_d = ST_NEWEST;
        end
      end
      ACT_PREV: begin
        if ((held_q != '0) && (offset != '0)) begin
          cursor_d      = slot_dec(cursor_q);
          pend_status_d = ST_SHOWN;
        end else begin
          pend_status_d = ST_OLDEST;
        end
      end
      ACT_CLEAR: begin
        oldest_d      = '0;
        cursor_d      = '0;
        held_d        = '0;
        next_num_d    = WORD_W'(1);
        pend_status_d = ST_CLEARED;
      end
      default: begin
        pend_status_d = (held_q != '0) ? ST_SHOWN : ST_EMPTY;
      end
    endcase
    pend_fill_d = FILL_W'(held_d);
  end

  // Record memory: write on append, read at the new cursor on every request
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_slot] <= wr_rec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q <= mem[cursor_d];
    end
  end

  // Log pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q   <= '0;
      cursor_q   <= '0;
      held_q     <= '0;
      next_num_q <= WORD_W'(1);
    end else if (in_fire) begin
      oldest_q   <= oldest_d;
      cursor_q   <= cursor_d;
      held_q     <= held_d;
      next_num_q <= next_num_d;
    end
  end

  // Hold the status and fill level while the read completes
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pend_status_q <= pend_status_d;
      pend_fill_q   <= pend_fill_d;
    end
  end

  // Sequence request acceptance and response hand-off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_FETCH;
          end
          if (out_valid_q && !out_stall_i) begin
            out_valid_q <= 1'b0;
          end
        end
        S_FETCH: begin
          if (out_free) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Load the response register; drop record fields unless shown
  always_ff @(posedge clk_i) begin
    if ((state_q == S_FETCH) && out_free) begin
      out_status_q <= pend_status_q;
      out_fill_q   <= pend_fill_q;
      out_rec_q    <= (pend_status_q == ST_SHOWN) ? rd_q : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign record_number_o = out_rec_q.number;
  assign record_kind_o   = out_rec_q.kind;
  assign record_value_o  = out_rec_q.value;
  assign record_stamp_o  = out_rec_q.stamp;
  assign fill_level_o    = out_fill_q;

endmodule

// ----- bench/bounded_history_log_with_cursor_test.sv -----
// ----------------------------------------------------------------------------
// bounded_history_log_with_cursor_test: self-checking bench for the history log
// Sends append, browse, clear and show requests with random idling on both
// channels. Checks every response field by field against its directed row
// or a behavioral model of the ring, its cursor and its sequence numbering.
// ----------------------------------------------------------------------------
module bounded_history_log_with_cursor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bhl_pkg::*;

  // Show has no package code; the spare codes act as show
  localparam logic [ACTION_W-1:0] ACT_SHOW   = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_SPARE5 = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE7 = 3'd7;

  localparam int unsigned ITEMS_PER_PHASE = 370;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned DIRECTED_ROWS   = 23;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    record_t             rec;
    logic [FILL_W-1:0]   fill;
  } response_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KIND_W-1:0]   kind;
    logic [WORD_W-1:0]   value;
    logic [WORD_W-1:0]   stamp;
    logic                typed;
    response_t           want;
  } step_row_t;

  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     in_valid_i      = 1'b0;
  logic                     in_stall_o;
  logic [ACTION_W-1:0]      action_i        = '0;
  logic [KIND_W-1:0]        sensor_kind_i   = '0;
  logic signed [WORD_W-1:0] sample_value_i  = '0;
  logic [WORD_W-1:0]        stamp_seconds_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i     = 1'b0;
  logic [STATUS_W-1:0]      status_o;
  logic [WORD_W-1:0]        record_number_o;
  logic [KIND_W-1:0]        record_kind_o;
  logic signed [WORD_W-1:0] record_value_o;
  logic [WORD_W-1:0]        record_stamp_o;
  logic [FILL_W-1:0]        fill_level_o;

  bounded_history_log_with_cursor dut (.*);

  always #5 clk_i = ~clk_i;

  // Behavioral copy of the ring, cursor and numbering
  record_t          log_mem [LOG_DEPTH];
  int unsigned      log_oldest      = 0;
  int unsigned      log_held        = 0;
  int unsigned      log_cursor      = 0;
  logic [WORD_W-1:0] log_next_number = 1;

  response_t   pending_responses [$];
  int unsigned mismatch_count    = 0;
  int unsigned quiet_cycles      = 0;
  int unsigned issued            = 0;
  int unsigned sender_idle_pct   = 36;
  int unsigned receiver_idle_pct = 65;

  // Directed requests: extremes, every code, empty/edge cases, clear restart
  step_row_t directed_steps [DIRECTED_ROWS] = '{
    '{ACT_SHOW,   8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_EMPTY,  '0, 6'd0}},
    '{ACT_NEXT,   8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_NEWEST, '0, 6'd0}},
    '{ACT_PREV,   8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_OLDEST, '0, 6'd0}},
    '{ACT_SPARE7, 8'h3C, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1, '{ST_EMPTY,  '0, 6'd0}},
    '{ACT_APPEND, 8'hFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{ST_APPENDED, '0, 6'd1}},
    '{ACT_SHOW,   8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{ST_SHOWN, '{32'd1, 8'hFF, 32'h8000_0000, 32'hFFFF_FFFF}, 6'd1}},
    '{ACT_NEXT,   8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_NEWEST, '0, 6'd1}},
    '{ACT_PREV,   8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_OLDEST, '0, 6'd1}},
    '{ACT_APPEND, 8'h00, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{ST_APPENDED, '0, 6'd2}},
    '{ACT_SHOW,   8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{ST_SHOWN, '{32'd1, 8'hFF, 32'h8000_0000, 32'hFFFF_FFFF}, 6'd2}},
    '{ACT_NEXT,   8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{ST_SHOWN, '{32'd2, 8'h00, 32'h7FFF_FFFF, 32'h0000_0000}, 6'd2}},
    '{ACT_NEXT,   8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_NEWEST, '0, 6'd2}},
    '{ACT_PREV,   8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{ST_SHOWN, '{32'd1, 8'hFF, 32'h8000_0000, 32'hFFFF_FFFF}, 6'd2}},
    '{ACT_SPARE5, 8'h81, 32'h0000_0001, 32'h8000_0001, 1'b0, '0},
    '{ACT_SPARE6, 8'h7E, 32'hFFFF_FFFE, 32'h7FFF_FFFE, 1'b0, '0},
    '{ACT_APPEND, 8'hA5, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, '0},
    '{ACT_NEXT,   8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{ACT_CLEAR,  8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_CLEARED, '0, 6'd0}},
    '{ACT_SHOW,   8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_EMPTY,  '0, 6'd0}},
    '{ACT_APPEND, 8'h5A, 32'h0000_0000, 32'h8000_0000, 1'b1, '{ST_APPENDED, '0, 6'd1}},
    '{ACT_SHOW,   8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{ST_SHOWN, '{32'd1, 8'h5A, 32'h0000_0000, 32'h8000_0000}, 6'd1}},
    '{ACT_PREV,   8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_OLDEST, '0, 6'd1}},
    '{ACT_NEXT,   8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_NEWEST, '0, 6'd1}}
  };

  // Apply one request to the log copy and return the response it should give
  function automatic response_t log_step_response(input logic [ACTION_W-1:0] act,
                                                  input logic [KIND_W-1:0]   in_kind,
                                                  input logic [WORD_W-1:0]   in_value,
                                                  input logic [WORD_W-1:0]   in_stamp);
    response_t   resp;
    int unsigned slot;
    int unsigned offset;
    logic        show;
    resp   = '0;
    show   = 1'b0;
    offset = (log_cursor + LOG_DEPTH - log_oldest) % LOG_DEPTH;
    case (act)
      ACT_APPEND: begin
        // Evict the oldest when full; drag a cursor resting on it along
        if (log_held >= LOG_DEPTH) begin
          if (log_cursor == log_oldest) log_cursor = (log_oldest + 1) % LOG_DEPTH;
          log_oldest = (log_oldest + 1) % LOG_DEPTH;
          log_held   = LOG_DEPTH - 1;
        end
        slot = (log_oldest + log_held) % LOG_DEPTH;
        log_mem[slot] = '{number: log_next_number, kind: in_kind,
                          value: in_value, stamp: in_stamp};
        log_next_number = log_next_number + 1;
        if (log_held == 0) log_cursor = slot;
        log_held    = log_held + 1;
        resp.status = ST_APPENDED;
      end
      ACT_NEXT: begin
        if (log_held > 0 && offset + 1 < log_held) begin
          log_cursor = (log_cursor + 1) % LOG_DEPTH;
          show       = 1'b1;
        end else begin
          resp.status = ST_NEWEST;
        end
      end
      ACT_PREV: begin
        if (log_held > 0 && offset > 0) begin
          log_cursor = (log_cursor + LOG_DEPTH - 1) % LOG_DEPTH;
          show       = 1'b1;
        end else begin
          resp.status = ST_OLDEST;
        end
      end
      ACT_CLEAR: begin
        log_oldest      = 0;
        log_held        = 0;
        log_cursor      = 0;
        log_next_number = 1;
        resp.status     = ST_CLEARED;
      end
      default: begin
        if (log_held > 0) show = 1'b1;
        else resp.status = ST_EMPTY;
      end
    endcase
    if (show) begin
      resp.status = ST_SHOWN;
      resp.rec    = log_mem[log_cursor];
    end
    resp.fill = log_held[FILL_W-1:0];
    return resp;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("%0t: %s mismatch: got %h, want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Present one request, hold it until taken, then record its expected response
  task automatic issue_request(input logic [ACTION_W-1:0] act,
                               input logic [KIND_W-1:0]   kind,
                               input logic [WORD_W-1:0]   value,
                               input logic [WORD_W-1:0]   stamp,
                               input logic                typed,
                               input response_t           want);
    response_t predicted;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    action_i        = act;
    sensor_kind_i   = kind;
    sample_value_i  = value;
    stamp_seconds_i = stamp;
    do @(posedge clk_i); while (in_stall_o);
    predicted = log_step_response(act, kind, value, stamp);
    pending_responses.push_back(typed ? want : predicted);
    issued++;
  endtask

  task automatic send_random(input logic [ACTION_W-1:0] act);
    issue_request(act, KIND_W'($urandom_range(0, 255)), pick_word(), pick_word(),
                  1'b0, '0);
  endtask

  // Hold off new requests until every response is back
  task automatic wait_for_responses();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
  endtask

  // Random request sequences: fill bursts, browse patterns, random codes and clears
  task automatic run_random_phase(input int unsigned sender_pct,
                                  input int unsigned receiver_pct);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n;
    sender_idle_pct   = sender_pct;
    receiver_idle_pct = receiver_pct;
    stop_at           = issued + ITEMS_PER_PHASE;
    while (issued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // Fill burst, often long enough to wrap the ring
        n = $urandom_range(1, LOG_DEPTH + 8);
        repeat (n) send_random(ACT_APPEND);
      end else if (pick < 45) begin
        // Park the cursor on the oldest record, then append past it
        n = log_held + 1;
        repeat (n) send_random(ACT_PREV);
        repeat ($urandom_range(1, 3)) send_random(ACT_APPEND);
        send_random(ACT_SHOW);
      end else if (pick < 60) begin
        // Walk to the newest record and one step beyond
        n = log_held + 1;
        repeat (n) send_random(ACT_NEXT);
        send_random(ACT_SHOW);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 8)) send_random(ACTION_W'($urandom_range(0, 7)));
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 6)) send_random($urandom_range(0, 1) ? ACT_NEXT : ACT_PREV);
      end else if (pick < 98) begin
        send_random(ACT_CLEAR);
      end else begin
        wait_for_responses();
        send_random(ACTION_W'($urandom_range(0, 7)));
      end
    end
    wait_for_responses();
  endtask

  // Receiver stall, changed at the falling edge
  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(0, 99) < receiver_idle_pct);
  end

  // Check each accepted response; watch for a hung handshake
  always @(posedge clk_i) begin : response_check
    response_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_responses.size() == 0) begin
          report_mismatch("unrequested response status", WORD_W'(status_o), '0);
        end else begin
          want = pending_responses.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", WORD_W'(status_o), WORD_W'(want.status));
          if (record_number_o !== want.rec.number)
            report_mismatch("record_number", record_number_o, want.rec.number);
          if (record_kind_o !== want.rec.kind)
            report_mismatch("record_kind", WORD_W'(record_kind_o),
                            WORD_W'(want.rec.kind));
          if (record_value_o !== want.rec.value)
            report_mismatch("record_value", record_value_o, want.rec.value);
          if (record_stamp_o !== want.rec.stamp)
            report_mismatch("record_stamp", record_stamp_o, want.rec.stamp);
          if (fill_level_o !== want.fill)
            report_mismatch("fill_level", WORD_W'(fill_level_o), WORD_W'(want.fill));
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned row;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows under the first idle pattern
    for (row = 0; row < DIRECTED_ROWS; row++) begin
      issue_request(directed_steps[row].action, directed_steps[row].kind,
                    directed_steps[row].value, directed_steps[row].stamp,
                    directed_steps[row].typed, directed_steps[row].want);
    end
    wait_for_responses();

    run_random_phase(36, 65);
    run_random_phase(65, 36);
    run_random_phase(0, 0);

    // Catch any stray response after the last one
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
